// ===== hdl/bmpd_pkg.sv =====
// Shared constants and result type for the BMP stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package bmpd_pkg;

    localparam int BMPD_MAX_DIM = 4096;

    localparam logic [5:0]  HDR_LAST  = 6'd53;
    localparam logic [31:0] HDR_LEN   = 32'd54;
    localparam logic [15:0] DEPTH_24  = 16'd24;
    localparam logic [15:0] DEPTH_32  = 16'd32;
    localparam logic [7:0]  ALPHA_RST = 8'd255;

    localparam logic       KIND_PIXEL = 1'b0;
    localparam logic       KIND_ERROR = 1'b1;

    localparam logic [1:0] ERR_DEPTH  = 2'd0;
    localparam logic [1:0] ERR_OFFSET = 2'd1;
    localparam logic [1:0] ERR_SIZE   = 2'd2;

    localparam int TDATA_W = 64;

    typedef struct packed {
        logic        kind;
        logic [1:0]  error_code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row_index;
        logic        last_pixel;
    } bmpd_result_t;

endpackage

`default_nettype wire

// ===== hdl/bmp_stream_decoder_top.sv =====
// Top level of the BMP stream decoder: byte stream in, RGBA pixel stream out.
//
// Input: one file byte per transfer on s_tdata[7:0]; s_tlast marks the last
// byte of a file, after which the next byte is taken as header byte 0.
// Output: one result per pixel (m_tuser = 0) or one per bad header
// (m_tuser = 1, error code in m_tdata[1:0]); m_tlast flags the last pixel.
// Configuration: cfg_valid/cfg_data write the alpha value, taken at once.
// A result is registered and appears on m_* in the cycle after the byte that completes it.
// Throughput: one byte per cycle while s_tready is high; every byte is handled by a single pass of
// the parser logic into its state and the result register.
// Header bytes (but the last one of a bad header) and offset/padding/fourth bytes give no result.
// Reset: aresetn low clears the parser to header byte 0, alpha to 255 and
// empties the result register.
// Stall: while m_tready is low and a result is held, s_tready drops; no
// result is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module bmp_stream_decoder_top #(
    parameter int MAX_DIM = bmpd_pkg::BMPD_MAX_DIM
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // file_byte
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // error_code[1:0], red[9:2], green[17:10], blue[25:18], alpha[33:26],
    // column[45:34], row_index[57:46], zero fill
    output logic [bmpd_pkg::TDATA_W-1:0]      m_tdata,
    output logic                              m_tuser,   // kind
    output logic                              m_tlast,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [7:0]                   cfg_data   // alpha_fill
);
    import bmpd_pkg::*;

    logic         step;
    logic         res_valid;
    bmpd_result_t res;
    bmpd_result_t out_res;

    assign cfg_ready = 1'b1;
    assign step      = s_tvalid && s_tready;

    bmpd_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .file_byte (s_tdata),
        .file_end  (s_tlast),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_alpha (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    bmpd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step && res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'd0, out_res.row_index, out_res.column, out_res.alpha,
                      out_res.blue, out_res.green, out_res.red, out_res.error_code};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_pixel;

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ERROR) |-> (m_tdata[63:2] == 62'd0) && !m_tlast)
        else $error("error result carries pixel data");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ERROR) |-> (m_tdata[1:0] != 2'd3))
        else $error("error code out of range");

    a_pix_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_PIXEL) |-> (m_tdata[1:0] == ERR_DEPTH))
        else $error("pixel result with nonzero error code");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== hdl/bmpd_parser.sv =====
// Header parser, offset skipper and pixel assembler, one byte per cycle while step is high.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_parser #(
    parameter int MAX_DIM = bmpd_pkg::BMPD_MAX_DIM
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic [7:0]            file_byte,
    input  wire logic                  file_end,
    input  wire logic                  cfg_write,
    input  wire logic [7:0]            cfg_alpha,
    output logic                       res_valid,
    output bmpd_pkg::bmpd_result_t     res
);
    import bmpd_pkg::*;

    localparam int CNT_W = (MAX_DIM < 2) ? 1 : $clog2(MAX_DIM + 1);
    localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXEL  = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd3;

    logic [7:0]       alpha_reg;
    logic [31:0]      count_reg, count_next;
    logic [31:0]      offset_reg, offset_next;
    logic [15:0]      width_reg, width_next;
    logic             width_big_reg, width_big_next;
    logic [15:0]      height_reg, height_next;
    logic             height_big_reg, height_big_next;
    logic [15:0]      bits_reg, bits_next;
    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       bip_reg, bip_next;
    logic [CNT_W-1:0] x_reg, x_next;
    logic [CNT_W-1:0] y_reg, y_next;
    logic [1:0]       pad_reg, pad_next;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       green_reg, green_next;

    logic [5:0]   hdr_idx;
    logic [16:0]  x_inc, y_inc;
    logic         row_done, img_done;
    logic [15:0]  x_wide, y_wide;
    logic         size_bad;

    assign hdr_idx  = count_reg[5:0];
    assign x_inc    = 17'(x_reg) + 17'd1;
    assign y_inc    = 17'(y_reg) + 17'd1;
    assign row_done = (x_inc == {1'b0, width_reg});
    assign img_done = (y_inc == {1'b0, height_reg});
    assign x_wide   = 16'(x_reg);
    assign y_wide   = 16'(y_reg);
    assign size_bad = width_big_reg || height_big_reg ||
                      ({1'b0, width_reg} > MAX_DIM_V) || ({1'b0, height_reg} > MAX_DIM_V);

    always_comb begin
        count_next      = count_reg;
        offset_next     = offset_reg;
        width_next      = width_reg;
        width_big_next  = width_big_reg;
        height_next     = height_reg;
        height_big_next = height_big_reg;
        bits_next       = bits_reg;
        phase_next      = phase_reg;
        bip_next        = bip_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        pad_next        = pad_reg;
        blue_next       = blue_reg;
        green_next      = green_reg;
        res_valid       = 1'b0;
        res             = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                unique case (hdr_idx) inside
                    6'd10: offset_next[7:0]   = file_byte;
                    6'd11: offset_next[15:8]  = file_byte;
                    6'd12: offset_next[23:16] = file_byte;
                    6'd13: offset_next[31:24] = file_byte;
                    6'd18: width_next[7:0]    = file_byte;
                    6'd19: width_next[15:8]   = file_byte;
                    6'd20, 6'd21: width_big_next  = width_big_reg || (file_byte != 8'd0);
                    6'd22: height_next[7:0]   = file_byte;
                    6'd23: height_next[15:8]  = file_byte;
                    6'd24, 6'd25: height_big_next = height_big_reg || (file_byte != 8'd0);
                    6'd28: bits_next[7:0]     = file_byte;
                    6'd29: bits_next[15:8]    = file_byte;
                    default: ;
                endcase
                count_next = count_reg + 32'd1;
                if (hdr_idx == HDR_LAST) begin
                    x_next   = '0;
                    y_next   = '0;
                    pad_next = '0;
                    bip_next = '0;
                    res.kind = KIND_ERROR;
                    if (bits_reg != DEPTH_24 && bits_reg != DEPTH_32) begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_DEPTH;
                        phase_next     = PH_IDLE;
                    end else if (offset_reg < HDR_LEN) begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_OFFSET;
                        phase_next     = PH_IDLE;
                    end else if (size_bad) begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_SIZE;
                        phase_next     = PH_IDLE;
                    end else if (width_reg == 16'd0 || height_reg == 16'd0) begin
                        phase_next = PH_IDLE;
                    end else if (offset_reg == HDR_LEN) begin
                        phase_next = PH_PIXEL;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (count_reg != 32'hFFFF_FFFF) begin
                    count_next = count_reg + 32'd1;
                end
                if (count_next >= offset_reg) begin
                    phase_next = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                if (pad_reg != 2'd0) begin
                    pad_next = pad_reg - 2'd1;
                end else begin
                    logic advance;
                    advance = 1'b0;
                    case (bip_reg)
                        2'd0: begin
                            blue_next = file_byte;
                            bip_next  = 2'd1;
                        end
                        2'd1: begin
                            green_next = file_byte;
                            bip_next   = 2'd2;
                        end
                        2'd2: begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_PIXEL;
                            res.red        = file_byte;
                            res.green      = green_reg;
                            res.blue       = blue_reg;
                            res.alpha      = alpha_reg;
                            res.column     = x_wide[11:0];
                            res.row_index  = y_wide[11:0];
                            res.last_pixel = row_done && img_done;
                            if (bits_reg == DEPTH_32) begin
                                bip_next = 2'd3;
                            end else begin
                                advance = 1'b1;
                            end
                        end
                        default: advance = 1'b1;
                    endcase
                    if (advance) begin
                        bip_next = 2'd0;
                        if (row_done) begin
                            x_next   = '0;
                            y_next   = y_inc[CNT_W-1:0];
                            pad_next = (bits_reg == DEPTH_24) ? width_reg[1:0] : 2'd0;
                            if (img_done) begin
                                phase_next = PH_IDLE;
                            end
                        end else begin
                            x_next = x_inc[CNT_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase

        if (file_end) begin
            count_next      = '0;
            offset_next     = '0;
            width_next      = '0;
            width_big_next  = 1'b0;
            height_next     = '0;
            height_big_next = 1'b0;
            bits_next       = '0;
            phase_next      = PH_HEADER;
            bip_next        = '0;
            x_next          = '0;
            y_next          = '0;
            pad_next        = '0;
            blue_next       = '0;
            green_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg      <= ALPHA_RST;
            count_reg      <= '0;
            offset_reg     <= '0;
            width_reg      <= '0;
            width_big_reg  <= 1'b0;
            height_reg     <= '0;
            height_big_reg <= 1'b0;
            bits_reg       <= '0;
            phase_reg      <= PH_HEADER;
            bip_reg        <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            pad_reg        <= '0;
            blue_reg       <= '0;
            green_reg      <= '0;
        end else begin
            if (cfg_write) begin
                alpha_reg <= cfg_alpha;
            end
            if (step) begin
                count_reg      <= count_next;
                offset_reg     <= offset_next;
                width_reg      <= width_next;
                width_big_reg  <= width_big_next;
                height_reg     <= height_next;
                height_big_reg <= height_big_next;
                bits_reg       <= bits_next;
                phase_reg      <= phase_next;
                bip_reg        <= bip_next;
                x_reg          <= x_next;
                y_reg          <= y_next;
                pad_reg        <= pad_next;
                blue_reg       <= blue_next;
                green_reg      <= green_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bmpd_out_reg.sv =====
// Result register between the parser and the output stream.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_out_reg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    input  wire bmpd_pkg::bmpd_result_t in_res,
    output logic                        in_ready,
    output logic                        out_valid,
    output bmpd_pkg::bmpd_result_t      out_res,
    input  wire logic                   out_ready
);
    import bmpd_pkg::*;

    logic         valid_reg;
    bmpd_result_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

`default_nettype wire

// ===== sim/bmpd_stream_checker.sv =====
// Checker for the BMP stream decoder: predicts results from input transfers and compares.
`timescale 1ns / 1ps

module bmpd_stream_checker #(
    parameter int MAX_DIM = bmpd_pkg::BMPD_MAX_DIM
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [7:0]                   s_tdata,
    input  wire logic                         s_tlast,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [bmpd_pkg::TDATA_W-1:0] m_tdata,
    input  wire logic                         m_tuser,
    input  wire logic                         m_tlast,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_ready,
    input  wire logic [7:0]                   cfg_data,
    output int                                pending_count,
    output int                                fail_count
);
    import bmpd_pkg::*;

    typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_IDLE} parse_phase_t;

    parse_phase_t phase;
    logic [31:0]  hdr_count;
    logic [31:0]  pix_offset;
    logic [31:0]  img_w;
    logic [31:0]  img_h;
    logic [15:0]  depth_bits;
    logic [1:0]   sub_byte;
    logic [31:0]  col;
    logic [31:0]  row;
    logic [1:0]   pad_todo;
    logic [7:0]   held_b;
    logic [7:0]   held_g;
    logic [7:0]   alpha_fill;

    bmpd_result_t decoded_results[$];
    int           failures = 0;
    int           results_seen = 0;

    function automatic void clear_parser();
        phase      = PH_HEADER;
        hdr_count  = '0;
        pix_offset = '0;
        img_w      = '0;
        img_h      = '0;
        depth_bits = '0;
        sub_byte   = '0;
        col        = '0;
        row        = '0;
        pad_todo   = '0;
        held_b     = '0;
        held_g     = '0;
    endfunction

    function automatic void advance_pixel();
        sub_byte = '0;
        col = col + 1;
        if (col >= img_w) begin
            col = '0;
            row = row + 1;
            if (depth_bits == DEPTH_24)
                pad_todo = 2'((32'd4 - ((img_w * 32'd3) & 32'd3)) & 32'd3);
            else
                pad_todo = '0;
            if (row >= img_h)
                phase = PH_IDLE;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] data, input logic at_end,
                                        output logic emit, output bmpd_result_t res);
        logic [31:0] pos;
        logic        bad;
        logic [1:0]  code;
        emit = 1'b0;
        res  = '0;
        bad  = 1'b0;
        code = ERR_DEPTH;
        case (phase)
            PH_HEADER: begin
                pos = hdr_count;
                if (pos >= 10 && pos <= 13)
                    pix_offset |= 32'(data) << (8 * (pos - 10));
                else if (pos >= 18 && pos <= 21)
                    img_w |= 32'(data) << (8 * (pos - 18));
                else if (pos >= 22 && pos <= 25)
                    img_h |= 32'(data) << (8 * (pos - 22));
                else if (pos >= 28 && pos <= 29)
                    depth_bits |= 16'(data) << (8 * (pos - 28));
                hdr_count = pos + 1;
                if (pos == HDR_LEN - 1) begin
                    if (depth_bits != DEPTH_24 && depth_bits != DEPTH_32) begin
                        bad  = 1'b1;
                        code = ERR_DEPTH;
                    end else if (pix_offset < HDR_LEN) begin
                        bad  = 1'b1;
                        code = ERR_OFFSET;
                    end else if (img_w > 32'(MAX_DIM) || img_h > 32'(MAX_DIM)) begin
                        bad  = 1'b1;
                        code = ERR_SIZE;
                    end
                    col      = '0;
                    row      = '0;
                    pad_todo = '0;
                    sub_byte = '0;
                    if (bad) begin
                        emit           = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = code;
                        phase          = PH_IDLE;
                    end else if (img_w == 0 || img_h == 0) begin
                        phase = PH_IDLE;
                    end else if (pix_offset == HDR_LEN) begin
                        phase = PH_PIXELS;
                    end else begin
                        phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (hdr_count != '1)
                    hdr_count = hdr_count + 1;
                if (hdr_count >= pix_offset)
                    phase = PH_PIXELS;
            end
            PH_PIXELS: begin
                if (pad_todo != 0) begin
                    pad_todo = pad_todo - 1;
                end else if (sub_byte == 0) begin
                    held_b   = data;
                    sub_byte = 2'd1;
                end else if (sub_byte == 1) begin
                    held_g   = data;
                    sub_byte = 2'd2;
                end else if (sub_byte == 2) begin
                    emit           = 1'b1;
                    res.kind       = KIND_PIXEL;
                    res.red        = data;
                    res.green      = held_g;
                    res.blue       = held_b;
                    res.alpha      = alpha_fill;
                    res.column     = col[11:0];
                    res.row_index  = row[11:0];
                    res.last_pixel = (col + 1 == img_w) && (row + 1 == img_h);
                    if (depth_bits == DEPTH_32)
                        sub_byte = 2'd3;
                    else
                        advance_pixel();
                end else begin
                    advance_pixel();
                end
            end
            default: ;
        endcase
        if (at_end)
            clear_parser();
    endfunction

    function automatic string describe(input bmpd_result_t r);
        return $sformatf("kind=%0d code=%0d r=%h g=%h b=%h a=%h col=%0d row=%0d last=%0d",
                         r.kind, r.error_code, r.red, r.green, r.blue, r.alpha,
                         r.column, r.row_index, r.last_pixel);
    endfunction

    function automatic void check_result(input bmpd_result_t got);
        bmpd_result_t want;
        results_seen++;
        if (decoded_results.size() == 0) begin
            if (failures < 10)
                $display("result %0d with none expected: %s", results_seen, describe(got));
            failures++;
            return;
        end
        want = decoded_results.pop_front();
        if (got.kind !== want.kind || got.error_code !== want.error_code ||
            got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.column !== want.column ||
            got.row_index !== want.row_index || got.last_pixel !== want.last_pixel) begin
            if (failures < 10) begin
                $display("result %0d mismatch", results_seen);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        logic         emit;
        bmpd_result_t want;
        bmpd_result_t got;
        if (!aresetn) begin
            clear_parser();
            alpha_fill = ALPHA_RST;
            decoded_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                alpha_fill = cfg_data;
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast, emit, want);
                if (emit)
                    decoded_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.kind       = m_tuser;
                got.error_code = m_tdata[1:0];
                got.red        = m_tdata[9:2];
                got.green      = m_tdata[17:10];
                got.blue       = m_tdata[25:18];
                got.alpha      = m_tdata[33:26];
                got.column     = m_tdata[45:34];
                got.row_index  = m_tdata[57:46];
                got.last_pixel = m_tlast;
                check_result(got);
            end
        end
        pending_count <= decoded_results.size();
        fail_count    <= failures;
    end

endmodule

// ===== sim/bmp_stream_decoder_top_test.sv =====
// Testbench top for the BMP stream decoder: file stimulus, stalls and verdict.
`timescale 1ns / 1ps

module bmp_stream_decoder_top_test;
    import bmpd_pkg::*;

    localparam int RANDOM_BYTES = 300;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_data  = '0;

    int   fail_count;
    int   pending_count;
    int   tx_idle_pct = 0;
    logic rx_stalls   = 1'b0;
    int   bytes_sent  = 0;

    logic [7:0] file_bytes[$];

    always #5 aclk = ~aclk;

    bmp_stream_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bmpd_stream_checker pixel_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .pending_count (pending_count),
        .fail_count    (fail_count)
    );

    // output-side backpressure
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (rx_stalls && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        bytes_sent += file_bytes.size();
    endtask

    // stop input and wait for every predicted result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_alpha(input logic [7:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // header with random filler, then for a decodable header with offset up to 200 skip area and
    // pixel rows with padding, then trailing bytes; keep > 0 cuts the file to at most that many bytes
    task automatic build_image(input logic [31:0] offset, input logic [31:0] width,
                               input logic [31:0] height, input logic [15:0] depth,
                               input int trail, input int keep);
        int row_bytes;
        file_bytes.delete();
        for (int i = 0; i < 54; i++)
            file_bytes.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) begin
            file_bytes[10 + i] = offset[8 * i +: 8];
            file_bytes[18 + i] = width[8 * i +: 8];
            file_bytes[22 + i] = height[8 * i +: 8];
        end
        file_bytes[28] = depth[7:0];
        file_bytes[29] = depth[15:8];
        if ((depth == DEPTH_24 || depth == DEPTH_32) && offset >= HDR_LEN && offset <= 200 &&
            width >= 1 && width <= 4096 && height >= 1 && height <= 4096) begin
            repeat (offset - HDR_LEN) file_bytes.push_back(8'($urandom));
            if (depth == DEPTH_32)
                row_bytes = width * 4;
            else
                row_bytes = width * 3 + ((4 - (width * 3) % 4) % 4);
            repeat (row_bytes * height) file_bytes.push_back(8'($urandom));
        end
        repeat (trail) file_bytes.push_back(8'($urandom));
        if (keep > 0)
            while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 2))
            0: begin
                tx_idle_pct = 0;
                rx_stalls   = 1'b0;
            end
            1: begin
                tx_idle_pct = 10;
                rx_stalls   = 1'b1;
            end
            default: begin
                tx_idle_pct = 40;
                rx_stalls   = 1'b1;
            end
        endcase
    endtask

    task automatic good_file(input int cut_chance);
        logic [15:0] dep;
        logic [31:0] off;
        int          keep;
        dep = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
        off = HDR_LEN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0);
        keep = ($urandom_range(0, 99) < cut_chance) ? $urandom_range(1, 120) : 0;
        build_image(off, $urandom_range(1, 6), $urandom_range(1, 4), dep,
                    $urandom_range(0, 5), keep);
    endtask

    initial begin
        int          roll;
        logic [15:0] dep;
        logic [31:0] big;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed files, first one with the reset alpha
        build_image(54, 3, 2, DEPTH_24, 0, 0);
        send_file();
        write_alpha(8'h00);
        build_image(58, 2, 2, DEPTH_32, 3, 0);
        send_file();
        build_image(54, 1, 1, DEPTH_24, 2, 0);
        send_file();
        build_image(54, 2, 2, 16'd16, 4, 0);
        send_file();
        build_image(54, 2, 2, 16'h0118, 2, 0);
        send_file();
        build_image(53, 2, 2, DEPTH_24, 2, 0);
        send_file();
        build_image(0, 2, 2, DEPTH_32, 0, 0);
        send_file();
        build_image(54, 4097, 1, DEPTH_24, 3, 0);
        send_file();
        build_image(54, 1, 32'hFFFF_FFFF, DEPTH_24, 0, 0);
        send_file();
        build_image(54, 32'h0001_0000, 1, DEPTH_32, 0, 0);
        send_file();
        // depth error wins over offset and size, offset over size
        build_image(10, 5000, 5000, 16'd8, 0, 0);
        send_file();
        build_image(20, 5000, 1, DEPTH_24, 0, 0);
        send_file();
        // empty images
        build_image(54, 0, 3, DEPTH_24, 6, 0);
        send_file();
        build_image(60, 2, 0, DEPTH_32, 6, 0);
        send_file();
        // file ends inside header, then inside pixel data
        build_image(54, 2, 2, DEPTH_24, 0, 20);
        send_file();
        build_image(56, 4, 3, DEPTH_24, 0, 70);
        send_file();
        // offset beyond any file length
        build_image(32'hFFFF_FFFF, 1, 1, DEPTH_24, 8, 0);
        send_file();
        write_alpha(8'hFF);

        // largest legal dimensions, cut short after a few pixels
        pick_idling();
        write_alpha(pick_alpha());
        build_image(54, 4096, 1, DEPTH_24, 0, 80);
        send_file();
        pick_idling();
        build_image(54, 1, 4096, DEPTH_32, 0, 80);
        send_file();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            pick_idling();
            if ($urandom_range(0, 99) < 15)
                write_alpha(pick_alpha());
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                good_file(15);
            end else if (roll < 80) begin
                case ($urandom_range(0, 2))
                    0: begin
                        dep = 16'($urandom);
                        if (dep == DEPTH_24 || dep == DEPTH_32)
                            dep = 16'd8;
                        build_image(54, 2, 2, dep, $urandom_range(0, 10), 0);
                    end
                    1: build_image($urandom_range(0, 53), 2, 2, DEPTH_24,
                                   $urandom_range(0, 10), 0);
                    default: begin
                        big = $urandom_range(0, 1) ? 32'd4097 : (32'($urandom) | 32'h2000);
                        if ($urandom_range(0, 1))
                            build_image(54, big, 2, DEPTH_32, $urandom_range(0, 10), 0);
                        else
                            build_image(54, 2, big, DEPTH_24, $urandom_range(0, 10), 0);
                    end
                endcase
            end else if (roll < 87) begin
                if ($urandom_range(0, 1))
                    build_image(54, 0, $urandom_range(0, 5), DEPTH_24, $urandom_range(0, 8), 0);
                else
                    build_image(56, $urandom_range(1, 5), 0, DEPTH_32, $urandom_range(0, 8), 0);
            end else if (roll < 93) begin
                file_bytes.delete();
                repeat ($urandom_range(1, 80)) file_bytes.push_back(8'($urandom));
            end else begin
                build_image(54, 2, 2, DEPTH_24, 0, $urandom_range(1, 53));
            end
            send_file();
        end

        // closing stretch without idling
        write_alpha(pick_alpha());
        tx_idle_pct = 0;
        rx_stalls   = 1'b0;
        repeat (3) begin
            good_file(0);
            send_file();
        end

        settle();
        if (fail_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bmpd_pkg.sv
hdl/bmpd_parser.sv
hdl/bmpd_out_reg.sv
hdl/bmp_stream_decoder_top.sv
sim/bmpd_stream_checker.sv
sim/bmp_stream_decoder_top_test.sv
